>>> hw/rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared constants for the binary to decimal ASCII converter
// Widths of the stream fields and of the BCD working register.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

	// input value width on the stream
	localparam int VALUE_W            = 32;
	// default number of value bits used
	localparam int DEFAULT_VALUE_BITS = 32;
	// decimal digits needed for a 32-bit value
	localparam int NUM_DIGITS         = 10;
	localparam int DIGIT_W            = 4;
	localparam int BCD_W              = NUM_DIGITS * DIGIT_W;
	// digit character width and its fixed upper bits ('0' is 6'b11_0000)
	localparam int CHAR_W             = 6;
	localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;
	// index of one digit in the BCD register
	localparam int POS_W              = $clog2(NUM_DIGITS);

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	// number of value bits that the 32-bit field can actually carry
	function automatic int eff_bits(input int bits);
		return (bits < VALUE_W) ? bits : VALUE_W;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/b2da_dabble.sv
// ----------------------------------------------------------------------------
// b2da_dabble: iterative double-dabble unit
// One add-3 adjust and one shift per cycle while a value is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_dabble #(
	parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] value_in,
	output logic                       done,
	output b2da_pkg::bcd_t             digits
);
	import b2da_pkg::*;

	localparam int STEP_W = $clog2(VALUE_BITS + 1);
	localparam int CAT_W  = BCD_W + VALUE_BITS;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [VALUE_BITS-1:0] bin_q;
	bcd_t                  bcd_q;

	bcd_t                  adj;
	logic [CAT_W-1:0]      cat;
	logic [CAT_W-1:0]      cat_sh;

	// add 3 to every digit of 5 or more, then shift the pair left by one
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= DIGIT_W'(5)) ? bcd_q[i] + DIGIT_W'(3) : bcd_q[i];
		end
		cat    = {adj, bin_q};
		cat_sh = {cat[CAT_W-2:0], 1'b0};
	end

	// sequencer: step count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_BITS);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value_in;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= cat_sh[VALUE_BITS-1:0];
			bcd_q <= cat_sh[CAT_W-1 -: BCD_W];
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

`default_nettype wire

>>> hw/rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary value to decimal ASCII digits
// Converts each input value and streams its digits, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one unsigned value per item on s_tdata. Master side
//   returns one item per decimal digit: m_tdata holds the ASCII code of the
//   digit ('0'..'9'), m_tlast marks the least significant digit. Leading
//   zeros are dropped; a zero value gives the single digit '0'.
//   After the accepting edge the double-dabble unit handles one value bit
//   per cycle; its done flag, the move to the emit state and the output
//   register lie between its last step and the first digit. Digits then
//   follow one per cycle while m_tready is high. A new value is taken only
//   once the previous one is through: s_tready is high only while no
//   conversion or digit
//   run is in progress; it rises once the last digit sits in the output
//   register, even if the receiver has not taken it yet.
//   A stalled receiver holds the current digit and pauses the run.
//   Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii #(
	parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [b2da_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [7:0]                        m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic                              m_tlast    // last
);
	import b2da_pkg::*;

	localparam int EFF_BITS = eff_bits(VALUE_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [POS_W-1:0]  pos_q;
	logic              m_tvalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic              in_acc;
	logic              out_free;
	logic              conv_done;
	bcd_t              digits;
	logic [POS_W-1:0]  lead;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	b2da_dabble #(
		.VALUE_BITS (EFF_BITS)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.value_in (s_tdata[EFF_BITS-1:0]),
		.done     (conv_done),
		.digits   (digits)
	);

	// highest nonzero digit; zero value starts at digit 0
	always_comb begin
		lead = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (digits[i] != '0) lead = POS_W'(i);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (conv_done) begin
						pos_q   <= lead;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (pos_q == '0) state_q <= ST_IDLE;
						else pos_q <= pos_q - POS_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			char_q <= {ASCII_DIGIT_HI, digits[pos_q]};
			last_q <= (pos_q == '0);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, char_q};
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker: port-level checks for the decimal ASCII converter
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// a value in work blocks the input for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted item");

	// every digit item is an ASCII decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] == 4'h3 && m_tdata[3:0] <= 4'd9))
		else $error("output item is not a decimal digit");

	// a stalled digit holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output item changed");

	// a run that is not over keeps the input closed
	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input ready in the middle of a digit run");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
